[hw/rtl/pa_pkg.sv]
// ----------------------------------------------------------------------------
// pa_pkg
// Shared types, request and mode codes for the primitive assembly unit.
// ----------------------------------------------------------------------------
package pa_pkg;

    localparam int unsigned IDX_W = 32;

    localparam logic [1:0] REQ_BEGIN  = 2'd0;
    localparam logic [1:0] REQ_VERTEX = 2'd1;
    localparam logic [1:0] REQ_END    = 2'd2;

    localparam logic [2:0] MODE_POINTS     = 3'd0;
    localparam logic [2:0] MODE_LINES      = 3'd1;
    localparam logic [2:0] MODE_LINE_STRIP = 3'd2;
    localparam logic [2:0] MODE_LINE_LOOP  = 3'd3;
    localparam logic [2:0] MODE_TRIANGLES  = 3'd4;
    localparam logic [2:0] MODE_TRI_STRIP  = 3'd5;
    localparam logic [2:0] MODE_TRI_FAN    = 3'd6;

    localparam logic [1:0] CNT_POINT    = 2'd1;
    localparam logic [1:0] CNT_LINE     = 2'd2;
    localparam logic [1:0] CNT_TRIANGLE = 2'd3;

    typedef logic [IDX_W-1:0] index_t;

    typedef struct packed {
        index_t     first_vertex;
        index_t     second_vertex;
        index_t     third_vertex;
        logic [1:0] vertex_count;
    } prim_t;

    typedef struct packed {
        logic  emit;
        prim_t prim;
    } pa_result_t;

    function automatic index_t pick3(input logic [1:0] sel, input index_t s0,
                                     input index_t s1, input index_t s2);
        index_t r;
        case (sel)
            2'd1:    r = s1;
            2'd2:    r = s2;
            default: r = s0;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/pa_req_if.sv]
// ----------------------------------------------------------------------------
// pa_req_if
// Request channel: begin, vertex and end transactions.
// ----------------------------------------------------------------------------
interface pa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] vertex_index;

    modport source (output valid, output req_type, output vertex_index, input ready);
    modport sink   (input valid, input req_type, input vertex_index, output ready);
endinterface

[hw/rtl/pa_prim_if.sv]
// ----------------------------------------------------------------------------
// pa_prim_if
// Primitive channel: one assembled point, line or triangle per transaction.
// ----------------------------------------------------------------------------
interface pa_prim_if;
    logic        valid;
    logic        ready;
    logic [31:0] first_vertex;
    logic [31:0] second_vertex;
    logic [31:0] third_vertex;
    logic [1:0]  vertex_count;

    modport source (output valid, output first_vertex, output second_vertex,
                    output third_vertex, output vertex_count, input ready);
    modport sink   (input valid, input first_vertex, input second_vertex,
                    input third_vertex, input vertex_count, output ready);
endinterface

[hw/rtl/pa_assembler.sv]
// ----------------------------------------------------------------------------
// pa_assembler
// Vertex ring, phase and slot pointer; forms the primitive, if any, for each request.
// ----------------------------------------------------------------------------
module pa_assembler (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [1:0]         req_type,
    input  pa_pkg::index_t     vertex_index,
    input  logic [2:0]         mode,
    output pa_pkg::pa_result_t result
);
    import pa_pkg::*;

    index_t     slot0_reg, slot1_reg, slot2_reg;
    index_t     s0, s1, s2;
    logic [1:0] phase_reg, phase_next;
    logic [1:0] ptr_reg, ptr_next;
    logic [1:0] p, p_inc, last, prev_idx, after;
    logic       wr_en;
    logic [1:0] wr_idx;

    assign p        = (ptr_reg == 2'd3) ? 2'd0 : ptr_reg;
    assign p_inc    = p + 2'd1;
    assign last     = (p == 2'd0) ? 2'd0 : ((p == 2'd1) ? 2'd2 : 2'd1);
    assign prev_idx = (p == 2'd0) ? 2'd2 : p - 2'd1;
    assign after    = (p == 2'd2) ? 2'd0 : p + 2'd1;

    assign wr_en  = (req_type == REQ_VERTEX) && (mode <= MODE_TRI_FAN);
    assign wr_idx = (mode == MODE_POINTS) ? 2'd0 : p;

    assign s0 = (wr_en && wr_idx == 2'd0) ? vertex_index : slot0_reg;
    assign s1 = (wr_en && wr_idx == 2'd1) ? vertex_index : slot1_reg;
    assign s2 = (wr_en && wr_idx == 2'd2) ? vertex_index : slot2_reg;

    always_comb
    begin
        phase_next = phase_reg;
        ptr_next   = ptr_reg;
        result     = '0;
        case (req_type)
            REQ_BEGIN:
            begin
                phase_next = 2'd0;
                ptr_next   = 2'd0;
            end
            REQ_END:
            begin
                if (mode == MODE_LINE_LOOP && phase_reg == 2'd2)
                begin
                    result.emit               = 1'b1;
                    result.prim.first_vertex  = pick3(last, s0, s1, s2);
                    result.prim.second_vertex = s0;
                    result.prim.vertex_count  = CNT_LINE;
                end
            end
            REQ_VERTEX:
            begin
                case (mode)
                    MODE_POINTS:
                    begin
                        result.emit              = 1'b1;
                        result.prim.first_vertex = vertex_index;
                        result.prim.vertex_count = CNT_POINT;
                    end
                    MODE_LINES:
                    begin
                        ptr_next = p_inc;
                        if (p_inc >= 2'd2)
                        begin
                            result.emit               = 1'b1;
                            result.prim.first_vertex  = s0;
                            result.prim.second_vertex = s1;
                            result.prim.vertex_count  = CNT_LINE;
                            ptr_next                  = 2'd0;
                        end
                    end
                    MODE_LINE_STRIP:
                    begin
                        if (phase_reg != 2'd0)
                        begin
                            result.emit               = 1'b1;
                            result.prim.first_vertex  = p_inc[0] ? s1 : s0;
                            result.prim.second_vertex = p_inc[0] ? s0 : s1;
                            result.prim.vertex_count  = CNT_LINE;
                        end
                        else
                        begin
                            phase_next = 2'd1;
                        end
                        ptr_next = (p_inc >= 2'd2) ? 2'd0 : p_inc;
                    end
                    MODE_LINE_LOOP:
                    begin
                        if (phase_reg == 2'd2)
                        begin
                            result.emit               = 1'b1;
                            result.prim.first_vertex  = p_inc[0] ? s1 : s2;
                            result.prim.second_vertex = p_inc[0] ? s2 : s1;
                            result.prim.vertex_count  = CNT_LINE;
                        end
                        else if (phase_reg == 2'd1)
                        begin
                            result.emit               = 1'b1;
                            result.prim.first_vertex  = s0;
                            result.prim.second_vertex = s1;
                            result.prim.vertex_count  = CNT_LINE;
                            phase_next                = 2'd2;
                        end
                        else
                        begin
                            phase_next = 2'd1;
                        end
                        ptr_next = (p_inc == 2'd3) ? 2'd1 : p_inc;
                    end
                    MODE_TRIANGLES:
                    begin
                        ptr_next = p_inc;
                        if (p_inc == 2'd3)
                        begin
                            result.emit               = 1'b1;
                            result.prim.first_vertex  = s0;
                            result.prim.second_vertex = s1;
                            result.prim.third_vertex  = s2;
                            result.prim.vertex_count  = CNT_TRIANGLE;
                            ptr_next                  = 2'd0;
                        end
                    end
                    MODE_TRI_STRIP, MODE_TRI_FAN:
                    begin
                        if (phase_reg == 2'd3)
                        begin
                            result.emit               = 1'b1;
                            result.prim.first_vertex  = pick3(prev_idx, s0, s1, s2);
                            result.prim.second_vertex = pick3(after, s0, s1, s2);
                            result.prim.third_vertex  = vertex_index;
                            result.prim.vertex_count  = CNT_TRIANGLE;
                            phase_next                = 2'd2;
                        end
                        else if (phase_reg == 2'd2)
                        begin
                            result.emit               = 1'b1;
                            result.prim.first_vertex  = pick3(after, s0, s1, s2);
                            result.prim.second_vertex = pick3(prev_idx, s0, s1, s2);
                            result.prim.third_vertex  = vertex_index;
                            result.prim.vertex_count  = CNT_TRIANGLE;
                            phase_next                = 2'd3;
                        end
                        else
                        begin
                            phase_next = phase_reg + 2'd1;
                        end
                        if (p_inc == 2'd3)
                            ptr_next = (mode == MODE_TRI_STRIP) ? 2'd0 : 2'd1;
                        else
                            ptr_next = p_inc;
                    end
                    default:
                    begin
                        ptr_next = ptr_reg;
                    end
                endcase
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            ptr_reg   <= 2'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && wr_en)
        begin
            case (wr_idx)
                2'd1:    slot1_reg <= vertex_index;
                2'd2:    slot2_reg <= vertex_index;
                default: slot0_reg <= vertex_index;
            endcase
        end
    end

endmodule

[hw/rtl/primitive_assembly_unit.sv]
// ----------------------------------------------------------------------------
// primitive_assembly_unit
// Assembles points, lines and triangles from a stream of vertex indices.
// ----------------------------------------------------------------------------
// The unit takes one request transaction per cycle and returns at most one
// primitive per request in the cycle after it is taken, through an output
// register; a new request is taken whenever that register is empty or being
// drained in the same cycle, so the rate is one request per clock while the
// output is not stalled. Write prim_mode only between draws.
module primitive_assembly_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       prim_mode_we,
    input  logic [2:0] prim_mode_wdata,
    pa_req_if.sink     req,
    pa_prim_if.source  prim
);
    import pa_pkg::*;

    logic [2:0] mode_reg;
    logic       step;
    pa_result_t result;
    logic       out_valid_reg, out_valid_next;
    prim_t      out_prim_reg;

    assign req.ready = !out_valid_reg || prim.ready;
    assign step      = req.valid && req.ready;

    pa_assembler u_assembler (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .req_type     (req.req_type),
        .vertex_index (req.vertex_index),
        .mode         (mode_reg),
        .result       (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = result.emit;
        else if (prim.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_POINTS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (prim_mode_we)
                mode_reg <= prim_mode_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && result.emit)
            out_prim_reg <= result.prim;
    end

    assign prim.valid         = out_valid_reg;
    assign prim.first_vertex  = out_prim_reg.first_vertex;
    assign prim.second_vertex = out_prim_reg.second_vertex;
    assign prim.third_vertex  = out_prim_reg.third_vertex;
    assign prim.vertex_count  = out_prim_reg.vertex_count;

endmodule

[tb/primitive_assembly_unit_tb.sv]
// ----------------------------------------------------------------------------
// primitive_assembly_unit_tb
// Self-checking bench for the primitive assembly unit. A request-level
// predictor tracks the mode, the three-slot index ring, the phase and the
// slot pointer, and computes the point, line or triangle that each accepted
// request yields. The bench runs short directed draws in every mode, then
// random draws with random mode switches, some of them inside a draw, and
// random stalls on both channels.
// ----------------------------------------------------------------------------
module primitive_assembly_unit_tb;
    import pa_pkg::*;

    localparam logic [2:0] MODE_UNUSED   = 3'd7;
    localparam logic [1:0] REQ_UNUSED    = 2'd3;
    localparam int         RANDOM_ITEMS  = 1450;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         MAX_PRINTED   = 20;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       prim_mode_we;
    logic [2:0] prim_mode_wdata;

    pa_req_if  req ();
    pa_prim_if prim ();

    primitive_assembly_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .prim_mode_we    (prim_mode_we),
        .prim_mode_wdata (prim_mode_wdata),
        .req             (req),
        .prim            (prim)
    );

    logic [2:0] mode_q  = MODE_POINTS;
    index_t     slot_q [3] = '{default: '0};
    logic [1:0] phase_q = 2'd0;
    logic [1:0] ptr_q   = 2'd0;

    prim_t expected_prims [$];
    prim_t want_prim;

    int errors        = 0;
    int items_sent    = 0;
    int prims_checked = 0;
    int points_seen   = 0;
    int lines_seen    = 0;
    int tris_seen     = 0;
    int pending_gap   = 0;
    int stall_left    = 0;
    bit steady        = 1'b0;
    bit req_busy      = 1'b0;

    always #2 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic index_t pick_index();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return index_t'($urandom_range(0, 15));
            default: return index_t'($urandom);
        endcase
    endfunction

    function automatic prim_t prim_of(input index_t a, input index_t b, input index_t c,
                                      input logic [1:0] n);
        prim_t p;
        p.first_vertex  = a;
        p.second_vertex = b;
        p.third_vertex  = c;
        p.vertex_count  = n;
        return p;
    endfunction

    function automatic bit assemble_step(input logic [1:0] kind, input index_t vi,
                                         output prim_t p);
        logic [1:0] k;
        logic [1:0] last;
        logic [1:0] prev;
        logic [1:0] nxt;
        bit         hit;
        hit = 1'b0;
        p   = '0;
        k   = (ptr_q == 2'd3) ? 2'd0 : ptr_q;
        case (kind)
            REQ_BEGIN:
            begin
                phase_q = 2'd0;
                ptr_q   = 2'd0;
            end
            REQ_END:
            begin
                if (mode_q == MODE_LINE_LOOP && phase_q == 2'd2)
                begin
                    last = (k == 2'd0) ? 2'd0 : 2'd3 - k;
                    p    = prim_of(slot_q[last], slot_q[0], '0, CNT_LINE);
                    hit  = 1'b1;
                end
            end
            REQ_VERTEX:
            begin
                case (mode_q)
                    MODE_POINTS:
                    begin
                        slot_q[0] = vi;
                        p   = prim_of(vi, '0, '0, CNT_POINT);
                        hit = 1'b1;
                    end
                    MODE_LINES:
                    begin
                        slot_q[k] = vi;
                        k++;
                        if (k >= 2'd2)
                        begin
                            p   = prim_of(slot_q[0], slot_q[1], '0, CNT_LINE);
                            hit = 1'b1;
                            k   = 2'd0;
                        end
                        ptr_q = k;
                    end
                    MODE_LINE_STRIP:
                    begin
                        slot_q[k] = vi;
                        k++;
                        if (phase_q != 2'd0)
                        begin
                            hit = 1'b1;
                            if (k[0])
                                p = prim_of(slot_q[1], slot_q[0], '0, CNT_LINE);
                            else
                                p = prim_of(slot_q[0], slot_q[1], '0, CNT_LINE);
                        end
                        else
                            phase_q = 2'd1;
                        if (k >= 2'd2)
                            k = 2'd0;
                        ptr_q = k;
                    end
                    MODE_LINE_LOOP:
                    begin
                        slot_q[k] = vi;
                        k++;
                        if (phase_q == 2'd2)
                        begin
                            hit = 1'b1;
                            if (k[0])
                                p = prim_of(slot_q[1], slot_q[2], '0, CNT_LINE);
                            else
                                p = prim_of(slot_q[2], slot_q[1], '0, CNT_LINE);
                        end
                        else if (phase_q == 2'd1)
                        begin
                            hit     = 1'b1;
                            p       = prim_of(slot_q[0], slot_q[1], '0, CNT_LINE);
                            phase_q = 2'd2;
                        end
                        else
                            phase_q = 2'd1;
                        if (k == 2'd3)
                            k = 2'd1;
                        ptr_q = k;
                    end
                    MODE_TRIANGLES:
                    begin
                        slot_q[k] = vi;
                        k++;
                        if (k == 2'd3)
                        begin
                            p   = prim_of(slot_q[0], slot_q[1], slot_q[2], CNT_TRIANGLE);
                            hit = 1'b1;
                            k   = 2'd0;
                        end
                        ptr_q = k;
                    end
                    MODE_TRI_STRIP, MODE_TRI_FAN:
                    begin
                        slot_q[k] = vi;
                        prev = (k == 2'd0) ? 2'd2 : k - 2'd1;
                        nxt  = (k >= 2'd2) ? k - 2'd2 : k + 2'd1;
                        if (phase_q == 2'd3)
                        begin
                            hit     = 1'b1;
                            p       = prim_of(slot_q[prev], slot_q[nxt], vi, CNT_TRIANGLE);
                            phase_q = 2'd2;
                        end
                        else if (phase_q == 2'd2)
                        begin
                            hit     = 1'b1;
                            p       = prim_of(slot_q[nxt], slot_q[prev], vi, CNT_TRIANGLE);
                            phase_q = 2'd3;
                        end
                        else
                            phase_q = phase_q + 2'd1;
                        k++;
                        if (k == 2'd3)
                            k = (mode_q == MODE_TRI_STRIP) ? 2'd0 : 2'd1;
                        ptr_q = k;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
        return hit;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        if (errors < MAX_PRINTED)
            $display("mismatch: %s: got %h, want %h", what, got, want);
        errors++;
    endtask

    task automatic send_req(input logic [1:0] kind, input index_t vi);
        prim_t p;
        if (pending_gap > 0)
            repeat (pending_gap) @(posedge clk);
        req.valid        <= 1'b1;
        req.req_type     <= kind;
        req.vertex_index <= vi;
        req_busy = 1'b1;
        do
            @(posedge clk);
        while (!req.ready);
        if (kind != REQ_UNUSED && (mode_q != MODE_UNUSED || kind == REQ_BEGIN))
            items_sent++;
        if (assemble_step(kind, vi, p))
            expected_prims.push_back(p);
        pending_gap = pick_gap();
        if (pending_gap > 0)
        begin
            req.valid <= 1'b0;
            req_busy = 1'b0;
        end
    endtask

    task automatic wait_drained();
        if (req_busy)
        begin
            req.valid <= 1'b0;
            req_busy    = 1'b0;
            pending_gap = 1;
        end
        while (expected_prims.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_mode(input logic [2:0] m);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        prim_mode_we    <= 1'b1;
        prim_mode_wdata <= m;
        @(posedge clk);
        prim_mode_we <= 1'b0;
        mode_q = m;
    endtask

    task automatic test_reset_mode();
        send_req(REQ_VERTEX, '0);
        send_req(REQ_VERTEX, '1);
    endtask

    task automatic test_triangles();
        write_mode(MODE_TRIANGLES);
        send_req(REQ_BEGIN, '0);
        send_req(REQ_VERTEX, 32'hA5A5_A5A5);
        send_req(REQ_VERTEX, 32'h5A5A_5A5A);
        send_req(REQ_VERTEX, 32'h0000_0001);
    endtask

    task automatic test_line_loop();
        write_mode(MODE_LINE_LOOP);
        send_req(REQ_BEGIN, '0);
        send_req(REQ_VERTEX, 32'd10);
        send_req(REQ_END, '0);
        send_req(REQ_VERTEX, 32'd20);
        send_req(REQ_END, '0);
    endtask

    task automatic test_loop_end_pointer_zero();
        write_mode(MODE_LINES);
        send_req(REQ_VERTEX, 32'd30);
        write_mode(MODE_LINE_LOOP);
        send_req(REQ_END, '0);
    endtask

    task automatic test_strip_keeps_phase();
        write_mode(MODE_LINE_STRIP);
        send_req(REQ_VERTEX, 32'd40);
    endtask

    task automatic test_tri_strip();
        write_mode(MODE_TRI_STRIP);
        send_req(REQ_BEGIN, '0);
        send_req(REQ_VERTEX, 32'd50);
        send_req(REQ_VERTEX, 32'd51);
        send_req(REQ_VERTEX, 32'd52);
    endtask

    task automatic test_loop_phase_three();
        write_mode(MODE_LINE_LOOP);
        send_req(REQ_VERTEX, 32'd60);
    endtask

    task automatic test_tri_fan();
        write_mode(MODE_TRI_FAN);
        send_req(REQ_BEGIN, '0);
        for (int i = 0; i < 4; i++)
            send_req(REQ_VERTEX, index_t'(70 + i));
    endtask

    task automatic test_unused_codes();
        send_req(REQ_UNUSED, '1);
        write_mode(MODE_UNUSED);
        send_req(REQ_VERTEX, 32'd80);
        send_req(REQ_END, '0);
    endtask

    task automatic test_random_draws();
        int         goal;
        int         n;
        int         r;
        logic [2:0] m;
        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal)
        begin
            if ($urandom_range(0, 99) < 4)
                m = MODE_UNUSED;
            else
                m = 3'($urandom_range(MODE_TRI_FAN, MODE_POINTS));
            steady = ($urandom_range(0, 5) == 0);
            write_mode(m);
            if ($urandom_range(0, 99) < 85)
                send_req(REQ_BEGIN, pick_index());
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            repeat (n)
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    send_req(REQ_UNUSED, pick_index());
                else if (r < 8)
                    send_req(REQ_END, pick_index());
                else if (r < 10)
                    send_req(REQ_BEGIN, pick_index());
                else
                    send_req(REQ_VERTEX, pick_index());
            end
            if ($urandom_range(0, 9) != 0)
                send_req(REQ_END, pick_index());
        end
        steady = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && prim.valid && prim.ready)
        begin
            if (expected_prims.size() == 0)
                report("primitive with none expected, first_vertex", prim.first_vertex, '0);
            else
            begin
                want_prim = expected_prims.pop_front();
                if (prim.first_vertex !== want_prim.first_vertex)
                    report("first_vertex", prim.first_vertex, want_prim.first_vertex);
                if (prim.second_vertex !== want_prim.second_vertex)
                    report("second_vertex", prim.second_vertex, want_prim.second_vertex);
                if (prim.third_vertex !== want_prim.third_vertex)
                    report("third_vertex", prim.third_vertex, want_prim.third_vertex);
                if (prim.vertex_count !== want_prim.vertex_count)
                    report("vertex_count", 32'(prim.vertex_count),
                           32'(want_prim.vertex_count));
                prims_checked++;
                case (want_prim.vertex_count)
                    CNT_POINT: points_seen++;
                    CNT_LINE:  lines_seen++;
                    default:   tris_seen++;
                endcase
            end
        end
        if (!rst_n)
            prim.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            prim.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            stall_left = pick_gap();
            prim.ready <= (stall_left == 0);
        end
    end

    initial
    begin
        rst_n            <= 1'b0;
        prim_mode_we     <= 1'b0;
        prim_mode_wdata  <= MODE_POINTS;
        req.valid        <= 1'b0;
        req.req_type     <= REQ_BEGIN;
        req.vertex_index <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_mode();
        test_triangles();
        test_line_loop();
        test_loop_end_pointer_zero();
        test_strip_keeps_phase();
        test_tri_strip();
        test_loop_phase_three();
        test_tri_fan();
        test_unused_codes();
        test_random_draws();

        wait_drained();
        repeat (SETTLE_CYCLES * 4) @(posedge clk);

        $display("covered %0d requests in all eight mode codes, with unused requests",
                 items_sent);
        $display("and in-draw mode switches; %0d primitives: %0d points, %0d lines, %0d tris",
                 prims_checked, points_seen, lines_seen, tris_seen);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("timeout with %0d primitives outstanding", expected_prims.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
